/* sv/qnl_pkg.sv */
// ----------------------------------------------------------------------------
// qnl_pkg: shared types and constants for the quaternion nlerp pipeline
// Lane bundle that travels between the pipeline sections.
// ----------------------------------------------------------------------------
`default_nettype none

package qnl_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned COMP_W = 16;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned MAG_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned ROOT_W = 32;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic [MAG_W-1:0] TOP_MAG = 32'h8000_0000;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0] neg;
    logic degen;
    logic allmax;
  } lanes_t;

endpackage

`default_nettype wire

/* sv/qnl_front.sv */
// ----------------------------------------------------------------------------
// qnl_front: dot product, hemisphere flip and weighted blend
// Five register stages; outputs the blend magnitudes and their signs.
// ----------------------------------------------------------------------------
`default_nettype none

module qnl_front
  import qnl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire comp_t [LANES-1:0]     a_i,
  input  wire comp_t [LANES-1:0]     b_i,
  input  wire logic [WEIGHT_W-1:0]   t_i,
  output logic                       valid_o,
  output lanes_t                     lanes_o
);

  logic [4:0] v_q;
  comp_t [LANES-1:0] a1_q, b1_q;
  logic [WEIGHT_W-1:0] t1_q, w1_q, t_d;
  logic signed [31:0] dp_q [LANES];
  logic signed [33:0] pa_q [LANES];
  logic signed [33:0] pb_q [LANES];
  logic signed [33:0] pa3_q [LANES];
  logic signed [33:0] pb3_q [LANES];
  logic signed [33:0] c_q [LANES];
  logic signed [33:0] dot_d;
  logic neg3_q;
  lanes_t out_q;

  assign t_d = (t_i > WEIGHT_ONE) ? WEIGHT_ONE : t_i;

  always_comb begin
    dot_d = '0;
    for (int i = 0; i < LANES; i++) begin
      dot_d = dot_d + 34'(dp_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q <= a_i;
      b1_q <= b_i;
      t1_q <= t_d;
      w1_q <= WEIGHT_ONE - t_d;
      for (int i = 0; i < LANES; i++) begin
        dp_q[i] <= a1_q[i] * b1_q[i];
        pa_q[i] <= a1_q[i] * $signed({1'b0, w1_q});
        pb_q[i] <= b1_q[i] * $signed({1'b0, t1_q});
        pa3_q[i] <= pa_q[i];
        pb3_q[i] <= pb_q[i];
        c_q[i] <= neg3_q ? (pa3_q[i] - pb3_q[i]) : (pa3_q[i] + pb3_q[i]);
        out_q.neg[i] <= c_q[i][33];
        out_q.mag[i] <= c_q[i][33] ? 32'(-c_q[i]) : c_q[i][31:0];
      end
      neg3_q <= dot_d[33];
      out_q.degen <= 1'b0;
      out_q.allmax <= 1'b0;
    end
  end

  assign valid_o = v_q[4];
  assign lanes_o = out_q;

endmodule

`default_nettype wire

/* sv/qnl_norm.sv */
// ----------------------------------------------------------------------------
// qnl_norm: block scaling of the magnitudes and sum of squares
// Six register stages: max, shift count, shift, squares, two adder levels.
// ----------------------------------------------------------------------------
`default_nettype none

module qnl_norm
  import qnl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire lanes_t            lanes_i,
  output logic                   valid_o,
  output lanes_t                 lanes_o,
  output logic [SUM_W-1:0]       sum_o
);

  logic [5:0] v_q;
  lanes_t l1_q, l2_q, l3_q, l4_q, l5_q, l6_q;
  lanes_t l1_d, l3_d, l4_d;
  logic [MAG_W-1:0] m_d, m01_d, m23_d, m1_q;
  logic [4:0] p_d, k_d, k2_q;
  logic pow2_d;
  logic [SUM_W-1:0] sq_q [LANES];
  logic [SUM_W-1:0] s01_q, s23_q, sum_q;

  assign m01_d = (lanes_i.mag[0] > lanes_i.mag[1]) ? lanes_i.mag[0] : lanes_i.mag[1];
  assign m23_d = (lanes_i.mag[2] > lanes_i.mag[3]) ? lanes_i.mag[2] : lanes_i.mag[3];
  assign m_d = (m01_d > m23_d) ? m01_d : m23_d;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m1_q[i]) p_d = 5'(i);
    end
    pow2_d = ((m1_q & (m1_q - 32'd1)) == '0);
    if (m1_q == '0) begin
      k_d = '0;
    end else if (pow2_d) begin
      k_d = 5'd31 - p_d;
    end else begin
      k_d = 5'd30 - p_d;
    end
  end

  always_comb begin
    l1_d = lanes_i;
    l1_d.degen = (m_d == '0);
    l3_d = l2_q;
    for (int i = 0; i < LANES; i++) begin
      l3_d.mag[i] = l2_q.mag[i] << k2_q;
    end
    l4_d = l3_q;
    l4_d.allmax = (l3_q.mag[0] == TOP_MAG) && (l3_q.mag[1] == TOP_MAG) &&
                  (l3_q.mag[2] == TOP_MAG) && (l3_q.mag[3] == TOP_MAG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1_q <= l1_d;
      m1_q <= m_d;
      l2_q <= l1_q;
      k2_q <= k_d;
      l3_q <= l3_d;
      l4_q <= l4_d;
      for (int i = 0; i < LANES; i++) begin
        sq_q[i] <= SUM_W'(l3_q.mag[i]) * SUM_W'(l3_q.mag[i]);
      end
      l5_q <= l4_q;
      s01_q <= sq_q[0] + sq_q[1];
      s23_q <= sq_q[2] + sq_q[3];
      l6_q <= l5_q;
      sum_q <= s01_q + s23_q;
    end
  end

  assign valid_o = v_q[5];
  assign lanes_o = l6_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

/* sv/qnl_sqrt.sv */
// ----------------------------------------------------------------------------
// qnl_sqrt: pipelined integer square root
// One result bit per register stage, 32 stages; lane data rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module qnl_sqrt
  import qnl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire lanes_t            lanes_i,
  input  wire logic [SUM_W-1:0]  sum_i,
  output logic                   valid_o,
  output lanes_t                 lanes_o,
  output logic [ROOT_W-1:0]      root_o
);

  logic [SUM_W-1:0]  rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0] res_w  [ROOT_W+1];
  lanes_t            lane_w [ROOT_W+1];
  logic              v_w    [ROOT_W+1];

  assign rem_w[0] = sum_i;
  assign res_w[0] = '0;
  assign lane_w[0] = lanes_i;
  assign v_w[0] = valid_i;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int unsigned Bit = ROOT_W - 1 - s;
    logic [SUM_W+1:0] trial;
    logic take;
    logic [SUM_W-1:0] rem_q;
    logic [ROOT_W-1:0] res_q;
    lanes_t lane_q;
    logic v_q;

    assign trial = ((SUM_W+2)'(res_w[s]) << (Bit + 1)) + ((SUM_W+2)'(1) << (2 * Bit));
    assign take = ((SUM_W+2)'(rem_w[s]) >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q <= lane_w[s];
        rem_q <= take ? SUM_W'((SUM_W+2)'(rem_w[s]) - trial) : rem_w[s];
        res_q <= take ? (res_w[s] | (ROOT_W'(1) << Bit)) : res_w[s];
      end
    end

    assign rem_w[s+1] = rem_q;
    assign res_w[s+1] = res_q;
    assign lane_w[s+1] = lane_q;
    assign v_w[s+1] = v_q;
  end

  assign valid_o = v_w[ROOT_W];
  assign lanes_o = lane_w[ROOT_W];
  assign root_o = res_w[ROOT_W];

endmodule

`default_nettype wire

/* sv/qnl_div.sv */
// ----------------------------------------------------------------------------
// qnl_div: rounded division of each magnitude by the norm, saturate, sign
// Entry stage, FRAC_BITS+1 restoring stages for four lanes, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qnl_div
  import qnl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire lanes_t            lanes_i,
  input  wire logic [ROOT_W-1:0] root_i,
  output logic                   valid_o,
  output comp_t [LANES-1:0]      r_o,
  output logic                   degen_o
);

  localparam int unsigned W = FRAC_BITS + 34;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NW = ROOT_W + 1;
  localparam int unsigned NSt = FRAC_BITS + 1;

  typedef struct packed {
    logic [LANES-1:0][W-1:0] rem;
    logic [LANES-1:0][QW-1:0] quo;
    logic [NW-1:0] n;
    logic [LANES-1:0] neg;
    logic degen;
  } div_t;

  div_t st_w [NSt+1];
  logic v_w [NSt+1];
  div_t ent_q;
  logic ent_v_q;
  logic [NW-1:0] n_d;
  comp_t [LANES-1:0] r_q;
  logic degen_q, out_v_q;

  assign n_d = lanes_i.allmax ? (NW'(1) << ROOT_W) : NW'(root_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      ent_v_q <= valid_i;
      out_v_q <= v_w[NSt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        ent_q.rem[i] <= (W'(lanes_i.mag[i]) << FRAC_BITS) + W'(n_d >> 1);
      end
      ent_q.quo <= '0;
      ent_q.n <= n_d;
      ent_q.neg <= lanes_i.neg;
      ent_q.degen <= lanes_i.degen;
    end
  end

  assign st_w[0] = ent_q;
  assign v_w[0] = ent_v_q;

  for (genvar s = 0; s < NSt; s++) begin : g_stage
    localparam int unsigned Bit = FRAC_BITS - s;
    logic [W-1:0] dvs;
    div_t st_d, st_q;
    logic v_q;

    assign dvs = W'(st_w[s].n) << Bit;

    always_comb begin
      st_d = st_w[s];
      for (int i = 0; i < LANES; i++) begin
        if (st_w[s].rem[i] >= dvs) begin
          st_d.rem[i] = st_w[s].rem[i] - dvs;
          st_d.quo[i] = st_w[s].quo[i] | (QW'(1) << Bit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q <= st_d;
      end
    end

    assign st_w[s+1] = st_q;
    assign v_w[s+1] = v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < LANES; i++) begin
        if (st_w[NSt].degen) begin
          r_q[i] <= '0;
        end else if (st_w[NSt].neg[i]) begin
          r_q[i] <= (32'(st_w[NSt].quo[i]) > 32'd32768) ? 16'sh8000 :
                    16'(17'd0 - 17'(st_w[NSt].quo[i]));
        end else begin
          r_q[i] <= (32'(st_w[NSt].quo[i]) > 32'd32767) ? 16'sh7fff :
                    16'(st_w[NSt].quo[i]);
        end
      end
      degen_q <= st_w[NSt].degen;
    end
  end

  assign valid_o = out_v_q;
  assign r_o = r_q;
  assign degen_o = degen_q;

endmodule

`default_nettype wire

/* sv/quaternion_nlerp.sv */
// ----------------------------------------------------------------------------
// quaternion_nlerp: normalized linear interpolation of two quaternions
// Fixed-point nlerp with shortest-arc flip, streaming in and out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis carries one request: quaternions a, b (signed
//   fixed point, FRAC_BITS fraction bits) and weight t in Q1.16; weights
//   above 1.0 clamp to 1.0. Master channel m_axis returns one result per
//   request, in order: the normalized blend and, in tuser, a degenerate
//   flag set when the blend has zero length (components are then zero).
//   Throughput: one request per cycle while the output is not stalled.
//   The 32-stage square root and the FRAC_BITS+1 stage divider follow
//   the blend and scaling stages.
//   The whole pipeline advances as one; when the receiver stalls with a
//   result waiting, every stage holds and s_axis_tready drops in the same
//   cycle, so nothing is dropped or repeated. A bubble in the output slot
//   lets the pipeline advance even while m_axis_tready is low.
//   Reset clears all valid bits; the pipeline is then empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_nlerp
  import qnl_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (16 each), weight (17), zero pad
  input  wire logic [151:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // r_w, r_x, r_y, r_z (16 each)
  output logic [63:0]       m_axis_tdata,
  // degenerate
  output logic              m_axis_tuser
);

  logic en;
  comp_t [LANES-1:0] a_in, b_in;
  logic front_v, norm_v, sqrt_v;
  lanes_t front_l, norm_l, sqrt_l;
  logic [SUM_W-1:0] sum;
  logic [ROOT_W-1:0] root;
  comp_t [LANES-1:0] r;

  // advance everything unless a finished result is stuck at the output
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack request fields
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a_in[i] = s_axis_tdata[COMP_W*i +: COMP_W];
      b_in[i] = s_axis_tdata[COMP_W*(LANES+i) +: COMP_W];
    end
  end

  // products, flip toward the short arc, blend
  qnl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .a_i     (a_in),
    .b_i     (b_in),
    .t_i     (s_axis_tdata[2*LANES*COMP_W +: WEIGHT_W]),
    .valid_o (front_v),
    .lanes_o (front_l)
  );

  // scale so the largest magnitude lies above 2^30 and at most 2^31, sum the squares
  qnl_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .lanes_i (front_l),
    .valid_o (norm_v),
    .lanes_o (norm_l),
    .sum_o   (sum)
  );

  qnl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (norm_v),
    .lanes_i (norm_l),
    .sum_i   (sum),
    .valid_o (sqrt_v),
    .lanes_o (sqrt_l),
    .root_o  (root)
  );

  // divide by the norm with rounding; the last stage is the output register
  qnl_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_v),
    .lanes_i (sqrt_l),
    .root_i  (root),
    .valid_o (m_axis_tvalid),
    .r_o     (r),
    .degen_o (m_axis_tuser)
  );

  assign m_axis_tdata = r;

endmodule

`default_nettype wire

/* sv/qnl_checker.sv */
// ----------------------------------------------------------------------------
// qnl_checker: port-level checks for quaternion_nlerp
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module qnl_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata,
  input wire logic         m_axis_tuser
);

  // intake stalls exactly when a result waits
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("s_axis_tready does not follow output stall");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("degenerate result with nonzero data");

  a_unit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata != 64'd0))
    else $error("normalized result is all zero");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind quaternion_nlerp qnl_checker u_qnl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quaternion_nlerp
// Drives requests of two quaternions and a weight, predicts each normalized
// blend in integer arithmetic and compares the results in order.
// ----------------------------------------------------------------------------
module testbench;
  import qnl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 14;
  localparam int unsigned LATENCY = FRAC + 46;

  typedef struct packed {
    logic [16:0] weight;
    comp_t [3:0] b;   // b[0] = w
    comp_t [3:0] a;   // a[0] = w
  } request_t;

  typedef struct packed {
    logic degen;
    comp_t [3:0] r;
  } blend_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [151:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  quaternion_nlerp #(.FRAC_BITS(FRAC)) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  request_t pending_requests[$];
  blend_t expected_blends[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 77;
  int unsigned hold_off_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= s) root = trial;
    end
    return root;
  endfunction

  // Blend, flip for the short arc, normalize and round half away from zero.
  function automatic blend_t nlerp_blend(request_t req);
    blend_t res;
    longint t, dot, sgn_b, c[4];
    longint unsigned g[4], peak, sum_sq, root, q;
    bit all_top;
    t = req.weight > 17'd65536 ? 65536 : longint'(req.weight);
    dot = 0;
    for (int k = 0; k < 4; k++) dot += longint'(req.a[k]) * longint'(req.b[k]);
    peak = 0;
    for (int k = 0; k < 4; k++) begin
      sgn_b = dot < 0 ? -longint'(req.b[k]) : longint'(req.b[k]);
      c[k] = longint'(req.a[k]) * (65536 - t) + sgn_b * t;
      g[k] = c[k] < 0 ? -c[k] : c[k];
      if (g[k] > peak) peak = g[k];
    end
    res = '0;
    if (peak == 0) begin
      res.degen = 1'b1;
      return res;
    end
    while ((peak << 1) <= 64'h8000_0000) begin
      peak <<= 1;
      for (int k = 0; k < 4; k++) g[k] <<= 1;
    end
    all_top = 1'b1;
    sum_sq = 0;
    for (int k = 0; k < 4; k++) begin
      if (g[k] != 64'h8000_0000) all_top = 1'b0;
      sum_sq += g[k] * g[k];
    end
    root = all_top ? 64'h1_0000_0000 : int_sqrt(sum_sq);
    for (int k = 0; k < 4; k++) begin
      q = ((g[k] << FRAC) + (root >> 1)) / root;
      if (c[k] < 0) begin
        if (q > 32768) q = 32768;
        res.r[k] = comp_t'(-longint'(q));
      end else begin
        if (q > 32767) q = 32767;
        res.r[k] = comp_t'(q);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    mismatches++;
  endtask

  // Driver: present the queue head, advance when the request is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= {23'd0, pending_requests[0]};
          expected_blends.push_back(nlerp_blend(pending_requests[0]));
          void'(pending_requests.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    blend_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_blends.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[15:0], 16'h0);
      end else begin
        want = expected_blends.pop_front();
        for (int k = 0; k < 4; k++)
          if (m_axis_tdata[16*k +: 16] !== want.r[k])
            report_mismatch($sformatf("r[%0d]", k), m_axis_tdata[16*k +: 16], want.r[k]);
        if (m_axis_tuser !== want.degen)
          report_mismatch("degenerate", 16'(m_axis_tuser), 16'(want.degen));
      end
    end
  end

  function automatic comp_t rand_comp();
    case ($urandom_range(5))
      0: return comp_t'(16'sh8000);
      1: return comp_t'(16'sh7fff);
      2: return comp_t'($urandom_range(32) - 16);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'(65537 + $urandom_range(65534));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic add_request(comp_t aw, comp_t ax, comp_t ay, comp_t az,
                             comp_t bw, comp_t bx, comp_t by, comp_t bz,
                             logic [16:0] w);
    request_t req;
    req.a = {az, ay, ax, aw};
    req.b = {bz, by, bx, bw};
    req.weight = w;
    pending_requests.push_back(req);
  endtask

  task automatic add_random(int unsigned count);
    request_t req;
    for (int unsigned n = 0; n < count; n++) begin
      for (int k = 0; k < 4; k++) begin
        req.a[k] = rand_comp();
        // Sometimes mirror a, opposite or equal, to hit the hemisphere flip.
        case ($urandom_range(9))
          0: req.b[k] = -req.a[k];
          1: req.b[k] = req.a[k];
          default: req.b[k] = rand_comp();
        endcase
      end
      req.weight = rand_weight();
      if ($urandom_range(19) == 0) req.weight = 17'd32768;
      pending_requests.push_back(req);
    end
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_blends.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    // Directed: extremes, unit input, zero blend, flip and zero dot.
    add_request(16384, 0, 0, 0, 16384, 0, 0, 0, 17'd0);
    add_request(16384, 0, 0, 0, 0, 16384, 0, 0, 17'd32768);
    add_request(16384, 0, 0, 0, -16384, 0, 0, 0, 17'd32768);
    add_request(16384, 0, 0, 0, 16384, 0, 0, 0, 17'd32768);
    add_request(0, 0, 0, 0, 0, 0, 0, 0, 17'd12345);
    add_request(0, 0, 0, 0, 5, 0, 0, 0, 17'd0);
    add_request(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 17'd65536);
    add_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 17'd1);
    add_request(32767, 32767, 32767, 32767, 1, 1, 1, 1, 17'h1ffff);
    add_request(32767, 0, 0, 0, 0, 0, 0, 32767, 17'd65537);
    add_request(1, 0, 0, 0, 0, 1, 0, 0, 17'd65535);
    add_request(-1, 0, 0, 0, 0, 0, 0, 0, 17'd1);
    add_request(100, 200, -300, 400, 100, 200, -300, 400, 17'd40000);
    add_request(-32768, 0, 0, 0, 0, 0, 0, -32768, 17'h10000);
    add_request(8192, 8192, 8192, 8192, 0, 0, 0, 0, 17'd0);
    add_request(0, 1, 0, 0, 0, -1, 0, 0, 17'd32768);
    add_random(585);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Long receiver hold-off to fill the pipeline and stall the input.
    @(posedge clk_i);
    hold_off_cycles <= 400;
    drain();
    send_idle_pct = 77;
    recv_idle_pct = 29;
    add_random(650);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(650);
    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("testbench failed");
    $finish;
  end

endmodule
